>>> rtl/core/fso_pkg.sv
package fso_pkg;

  localparam int QW  = 15;
  localparam int AW  = 17;
  localparam int VW  = 19;
  localparam int BW  = 22;
  localparam int DVW = 20;
  localparam int MW  = 16;
  localparam int WSW = 18;
  localparam int OSW = 21;
  localparam int PW  = 35;
  localparam int DZW = 22;
  localparam int NW  = 36;
  localparam int FDW = 23;

  localparam logic signed [BW-1:0] SAFE_GAP    = BW'(2560);
  localparam logic signed [BW-1:0] CRIT_L0_OFF = BW'(2048);
  localparam logic signed [BW-1:0] CRIT_L1_OFF = BW'(512);
  localparam logic signed [BW-1:0] CRIT_R1     = BW'(30720);
  localparam logic signed [BW-1:0] CRIT_R0     = BW'(46080);
  localparam logic signed [BW-1:0] HIGH_R1     = BW'(160000);
  localparam logic signed [BW-1:0] HIGH_R0     = BW'(320000);
  localparam logic [MW-1:0]        Q_ONE       = MW'(32768);

  localparam logic [OSW-1:0] OUT_NEAR      = OSW'(7);
  localparam logic [OSW-1:0] OUT_CRIT      = OSW'(20);
  localparam logic [OSW-1:0] OUT_NEAR_HIGH = OSW'(10);
  localparam logic [DZW-1:0] OUT_SCALE     = DZW'(20);

  typedef enum logic [1:0] {
    CFG_START = 2'd0,
    CFG_FULL  = 2'd1,
    CFG_SPEED = 2'd2,
    CFG_MAX   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MK_ZERO,
    MK_ONE,
    MK_SLOPE
  } mem_kind_t;

  typedef struct packed {
    mem_kind_t        kind;
    logic [DVW-1:0]   rem;
    logic [DVW-1:0]   den;
    logic [QW-1:0]    q;
  } lane_t;

  typedef struct packed {
    logic [FDW-1:0] rem;
    logic [FDW-1:0] den;
    logic [QW-1:0]  lo;
    logic [QW-1:0]  q;
    logic           zero;
    logic           neg;
  } fdiv_t;

endpackage

>>> rtl/core/fuzzy_setpoint_offset_unit.sv
// Throughput: one item per cycle unless out_stall holds the pipeline; two
// 15-stage restoring dividers, one quotient bit per stage, set the depth.
// The whole pipeline holds in place while a result waits under out_stall.
// Reset (rst_n low at a clock edge) empties the pipeline and restores the
// configuration registers to their defaults.
module fuzzy_setpoint_offset_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [15:0]          in_arm_angle,
  input  logic signed [16:0]          in_arm_velocity,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [14:0]          out_setpoint_offset,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  fso_pkg::cfg_idx_t           cfg_index,
  input  logic [15:0]                 cfg_data
);
  import fso_pkg::*;

  function automatic lane_t classify(logic signed [BW-1:0] x, logic signed [BW-1:0] l0,
                                     logic signed [BW-1:0] l1, logic signed [BW-1:0] r1,
                                     logic signed [BW-1:0] r0);
    lane_t o;
    logic signed [BW-1:0] num;
    logic signed [BW-1:0] den;
    o = '0;
    num = '0;
    den = '0;
    if (x <= l0 || x >= r0) begin
      o.kind = MK_ZERO;
    end else if (x >= l1 && x <= r1) begin
      o.kind = MK_ONE;
    end else if (x < l1) begin
      o.kind = MK_SLOPE;
      num = x - l0;
      den = l1 - l0;
    end else begin
      o.kind = MK_SLOPE;
      num = r0 - x;
      den = r0 - r1;
    end
    o.rem = num[DVW-1:0];
    o.den = den[DVW-1:0];
    return o;
  endfunction

  function automatic lane_t lane_step(lane_t a);
    lane_t b;
    logic [DVW:0] t;
    b = a;
    t = {a.rem, 1'b0};
    if (t >= {1'b0, a.den}) begin
      b.rem = DVW'(t - {1'b0, a.den});
      b.q = {a.q[QW-2:0], 1'b1};
    end else begin
      b.rem = t[DVW-1:0];
      b.q = {a.q[QW-2:0], 1'b0};
    end
    return b;
  endfunction

  function automatic fdiv_t fdiv_step(fdiv_t a);
    fdiv_t b;
    logic [FDW:0] t;
    b = a;
    t = {a.rem, a.lo[QW-1]};
    b.lo = {a.lo[QW-2:0], 1'b0};
    if (t >= {1'b0, a.den}) begin
      b.rem = FDW'(t - {1'b0, a.den});
      b.q = {a.q[QW-2:0], 1'b1};
    end else begin
      b.rem = t[FDW-1:0];
      b.q = {a.q[QW-2:0], 1'b0};
    end
    return b;
  endfunction

  function automatic logic [MW-1:0] mem_val(lane_t a);
    logic [MW-1:0] v;
    case (a.kind)
      MK_ONE:   v = Q_ONE;
      MK_SLOPE: v = {1'b0, a.q};
      default:  v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [MW-1:0] umin(logic [MW-1:0] a, logic [MW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  logic [14:0] cfg_start_r;
  logic [14:0] cfg_full_r;
  logic [15:0] cfg_speed_r;
  logic [13:0] cfg_max_r;

  logic adv;

  assign cfg_ready = 1'b1;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_start_r <= 15'd7680;
      cfg_full_r  <= 15'd11520;
      cfg_speed_r <= 16'd3200;
      cfg_max_r   <= 14'd1280;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START: cfg_start_r <= cfg_data[14:0];
        CFG_FULL:  cfg_full_r  <= cfg_data[14:0];
        CFG_SPEED: cfg_speed_r <= cfg_data;
        CFG_MAX:   cfg_max_r   <= cfg_data[13:0];
        default:   cfg_start_r <= cfg_start_r;
      endcase
    end
  end

  // Stage 1: doubled angle magnitude and five times the velocity magnitude.
  logic [15:0]   ang_abs;
  logic [16:0]   vel_abs;
  logic [AW-1:0] xa_nxt;
  logic [VW-1:0] xv_nxt;
  logic [AW-1:0] xa_r;
  logic [VW-1:0] xv_r;
  logic          p1_neg_r;
  logic          p1_valid_r;

  always_comb begin
    ang_abs = in_arm_angle[15] ? 16'(-in_arm_angle) : 16'(in_arm_angle);
    vel_abs = in_arm_velocity[16] ? 17'(-in_arm_velocity) : 17'(in_arm_velocity);
    xa_nxt  = {ang_abs, 1'b0};
    xv_nxt  = VW'({vel_abs, 2'b00}) + VW'(vel_abs);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xa_r     <= xa_nxt;
      xv_r     <= xv_nxt;
      p1_neg_r <= in_arm_angle[15];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (adv) begin
      p1_valid_r <= in_valid;
    end
  end

  // Stage 2: membership classification, then one quotient bit per stage.
  logic signed [BW-1:0] s_w, f_w, t_w, xa_w, xv_w, s2, f2, safe_r1, t3, t5;
  lane_t lane_nxt [0:3];

  always_comb begin
    s_w  = signed'(BW'(cfg_start_r));
    f_w  = signed'(BW'(cfg_full_r));
    t_w  = signed'(BW'(cfg_speed_r));
    xa_w = signed'(BW'(xa_r));
    xv_w = signed'(BW'(xv_r));
    s2   = s_w <<< 1;
    f2   = f_w <<< 1;
    safe_r1 = s2 - SAFE_GAP;
    if (safe_r1 < 0) begin
      safe_r1 = '0;
    end
    t3 = t_w + (t_w <<< 1);
    t5 = t_w + (t_w <<< 2);
    lane_nxt[0] = classify(xa_w, '0, '0, safe_r1, s2);
    lane_nxt[1] = classify(xa_w, s2, s_w + f_w, s_w + f_w, f2);
    lane_nxt[2] = classify(xa_w, f2 - CRIT_L0_OFF, f2 - CRIT_L1_OFF, CRIT_R1, CRIT_R0);
    lane_nxt[3] = classify(xv_w, t3, t5, HIGH_R1, HIGH_R0);
  end

  lane_t md_r     [0:QW][0:3];
  logic  md_neg_r [0:QW];
  logic  md_v_r   [0:QW];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        md_r[0][i] <= lane_nxt[i];
      end
      md_neg_r[0] <= p1_neg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_v_r[0] <= 1'b0;
    end else if (adv) begin
      md_v_r[0] <= p1_valid_r;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_mdiv
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 4; i++) begin
          md_r[k][i] <= lane_step(md_r[k-1][i]);
        end
        md_neg_r[k] <= md_neg_r[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        md_v_r[k] <= 1'b0;
      end else if (adv) begin
        md_v_r[k] <= md_v_r[k-1];
      end
    end
  end

  // Rule weights and the two sums.
  logic [MW-1:0]  m_safe, m_near, m_crit, m_high, w_ch, w_nh;
  logic [WSW-1:0] wsum_nxt, wsum_r;
  logic [OSW-1:0] osum_nxt, osum_r;
  logic           ws_neg_r, ws_v_r;

  always_comb begin
    m_safe = mem_val(md_r[QW][0]);
    m_near = mem_val(md_r[QW][1]);
    m_crit = mem_val(md_r[QW][2]);
    m_high = mem_val(md_r[QW][3]);
    w_ch   = umin(m_crit, m_high);
    w_nh   = umin(m_near, m_high);
    wsum_nxt = WSW'(m_safe) + WSW'(m_near) + WSW'(m_crit) + WSW'(w_ch) + WSW'(w_nh);
    osum_nxt = OSW'(m_near) * OUT_NEAR + OSW'(m_crit) * OUT_CRIT
             + OSW'(w_ch) * OUT_CRIT + OSW'(w_nh) * OUT_NEAR_HIGH;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wsum_r   <= wsum_nxt;
      osum_r   <= osum_nxt;
      ws_neg_r <= md_neg_r[QW];
    end
  end

  // Scale by max_offset.
  logic [PW-1:0]  prod_r;
  logic [DZW-1:0] den20_r;
  logic           pz_r, pn_neg_r, pn_v_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r   <= PW'(osum_r) * PW'(cfg_max_r);
      den20_r  <= DZW'(wsum_r) * OUT_SCALE;
      pz_r     <= (wsum_r == '0);
      pn_neg_r <= ws_neg_r;
    end
  end

  // Rounded average: (2*num + den) / (2*den), one quotient bit per stage.
  logic [NW-1:0] nn;
  fdiv_t         fd_nxt;
  fdiv_t         fd_r [0:QW];
  logic          fd_v_r [0:QW];

  always_comb begin
    nn = NW'({prod_r, 1'b0}) + NW'(den20_r);
    fd_nxt.rem  = FDW'(nn[NW-1:QW]);
    fd_nxt.den  = {den20_r, 1'b0};
    fd_nxt.lo   = nn[QW-1:0];
    fd_nxt.q    = '0;
    fd_nxt.zero = pz_r;
    fd_nxt.neg  = pn_neg_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fd_r[0] <= fd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_v_r    <= 1'b0;
      pn_v_r    <= 1'b0;
      fd_v_r[0] <= 1'b0;
    end else if (adv) begin
      ws_v_r    <= md_v_r[QW];
      pn_v_r    <= ws_v_r;
      fd_v_r[0] <= pn_v_r;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_fdiv
    always_ff @(posedge clk) begin
      if (adv) begin
        fd_r[k] <= fdiv_step(fd_r[k-1]);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        fd_v_r[k] <= 1'b0;
      end else if (adv) begin
        fd_v_r[k] <= fd_v_r[k-1];
      end
    end
  end

  // Clamp, sign and output register.
  logic [QW-1:0]      mag;
  logic signed [14:0] res_nxt;
  logic signed [14:0] res_r;
  logic               out_valid_r;

  always_comb begin
    mag = fd_r[QW].zero ? '0 : fd_r[QW].q;
    if (mag > {1'b0, cfg_max_r}) begin
      mag = {1'b0, cfg_max_r};
    end
    res_nxt = fd_r[QW].neg ? signed'(15'(-mag)) : signed'(mag);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fd_v_r[QW];
    end
  end

  assign out_valid = out_valid_r;
  assign out_setpoint_offset = res_r;

  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (16'(signed'(res_r)) <= signed'({2'b00, cfg_max_r})
                  && 16'(signed'(res_r)) >= -signed'({2'b00, cfg_max_r})))
    else $error("setpoint offset exceeds max_offset");

  a_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (fd_v_r[QW] && fd_r[QW].zero && adv) |=> (res_r == '0))
    else $error("item with no active rule gave a nonzero offset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(p1_valid_r) && $stable(pn_v_r) && $stable(fd_v_r[QW])))
    else $error("pipeline moved while the output was stalled");

  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (fd_v_r[QW] && !fd_r[QW].neg && adv) |=> !res_r[14])
    else $error("non-negative angle gave a negative offset");

endmodule

>>> bench/fuzzy_setpoint_offset_unit_tb.sv
module fuzzy_setpoint_offset_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fso_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 80;

  typedef struct {
    logic signed [14:0] offset;
  } offset_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_arm_angle;
  logic signed [16:0] in_arm_velocity;
  logic               out_valid;
  logic               out_stall;
  logic signed [14:0] out_setpoint_offset;
  logic               cfg_valid;
  logic               cfg_ready;
  cfg_idx_t           cfg_index;
  logic [15:0]        cfg_data;

  longint  start_angle;
  longint  full_angle;
  longint  speed_threshold;
  longint  offset_limit;
  offset_t expected_offsets[$];
  int      mismatch_count;
  int      idle_cycles;
  bit      hold_receiver;
  bit      stall_enable;

  fuzzy_setpoint_offset_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_arm_angle        (in_arm_angle),
    .in_arm_velocity     (in_arm_velocity),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_setpoint_offset (out_setpoint_offset),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint grade_slope(longint num, longint den);
    return (num * 32768) / den;
  endfunction

  function automatic longint grade_triangle(longint x, longint l, longint p, longint r);
    if (x <= l || x >= r) return 0;
    if (x == p) return 32768;
    if (x < p) return grade_slope(x - l, p - l);
    return grade_slope(r - x, r - p);
  endfunction

  function automatic longint grade_trapezoid(longint x, longint l0, longint l1,
                                             longint r1, longint r0);
    if (x <= l0 || x >= r0) return 0;
    if (x >= l1 && x <= r1) return 32768;
    if (x < l1) return grade_slope(x - l0, l1 - l0);
    return grade_slope(r0 - x, r0 - r1);
  endfunction

  function automatic logic signed [14:0] predict_offset(logic signed [15:0] angle,
                                                       logic signed [16:0] velocity);
    longint a;
    longint v;
    longint xa;
    longint xv;
    longint safe_top;
    longint safe;
    longint near;
    longint crit;
    longint high;
    longint wsum;
    longint osum;
    longint mag;
    longint den;
    a = angle;
    v = velocity;
    xa = 2 * (a < 0 ? -a : a);
    xv = 5 * (v < 0 ? -v : v);
    safe_top = 2 * start_angle - 2560;
    if (safe_top < 0) safe_top = 0;
    safe = grade_trapezoid(xa, 0, 0, safe_top, 2 * start_angle);
    near = grade_triangle(xa, 2 * start_angle, start_angle + full_angle, 2 * full_angle);
    crit = grade_trapezoid(xa, 2 * full_angle - 2048, 2 * full_angle - 512, 30720, 46080);
    high = grade_trapezoid(xv, 3 * speed_threshold, 5 * speed_threshold, 160000, 320000);
    wsum = safe + near + crit + (crit < high ? crit : high) + (near < high ? near : high);
    osum = 7 * near + 20 * crit + 20 * (crit < high ? crit : high)
         + 10 * (near < high ? near : high);
    mag = 0;
    if (wsum > 0) begin
      den = 20 * wsum;
      mag = (2 * osum * offset_limit + den) / (2 * den);
    end
    if (mag > offset_limit) mag = offset_limit;
    return 15'(a >= 0 ? mag : -mag);
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic write_register(cfg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_START: start_angle     = value & 16'h7FFF;
      CFG_FULL:  full_angle      = value & 16'h7FFF;
      CFG_SPEED: speed_threshold = value;
      CFG_MAX:   offset_limit    = value & 16'h3FFF;
      default:   ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(int s, int f, int t, int m);
    wait (expected_offsets.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_register(CFG_START, 16'(s));
    write_register(CFG_FULL, 16'(f));
    write_register(CFG_SPEED, 16'(t));
    write_register(CFG_MAX, 16'(m));
  endtask

  // Caller is at a falling edge; returns at a falling edge after acceptance.
  task automatic send_sample(logic signed [15:0] angle, logic signed [16:0] velocity);
    in_valid        <= 1'b1;
    in_arm_angle    <= angle;
    in_arm_velocity <= velocity;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_offsets.push_back('{offset: predict_offset(angle, velocity)});
    @(negedge clk);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  task automatic send_random(int count, bit bursty);
    int left;
    int burst;
    logic signed [15:0] angle;
    logic signed [16:0] velocity;
    left = count;
    @(negedge clk);
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && left > 0) begin
        case ($urandom_range(0, 3))
          0: angle = 16'($urandom);
          default: angle = 16'(int'($urandom_range(0, 46080)) - 23040);
        endcase
        case ($urandom_range(0, 3))
          0: velocity = 17'($urandom);
          1: velocity = 17'(int'($urandom_range(0, 12000)) - 6000);
          default: velocity = 17'(int'($urandom_range(0, 131071)) - 65536);
        endcase
        send_sample(angle, velocity);
        burst--;
        left--;
      end
      if (bursty && $urandom_range(0, 3) != 0) pause_sender();
    end
    in_valid <= 1'b0;
  endtask

  task automatic test_directed_extremes();
    @(negedge clk);
    send_sample(16'sd0, 17'sd0);
    send_sample(16'sd1, 17'sd0);
    send_sample(-16'sd1, 17'sd0);
    send_sample(16'sd7680, 17'sd0);
    send_sample(16'sd9600, 17'sd0);
    send_sample(-16'sd9600, 17'sd5000);
    send_sample(16'sd11520, 17'sd3200);
    send_sample(16'sd10752, 17'sd1920);
    send_sample(16'sd23040, 17'sd65535);
    send_sample(-16'sd23040, -17'sd65536);
    send_sample(16'sh8000, 17'h10000);
    send_sample(16'sh7FFF, 17'h0FFFF);
    send_sample(16'sd15360, 17'sd32000);
    send_sample(-16'sd12000, -17'sd4000);
    send_sample(16'sd8000, 17'sd64000);
    in_valid <= 1'b0;
  endtask

  task automatic test_default_random();
    send_random(300, 1'b1);
  endtask

  task automatic test_zero_thresholds();
    configure(0, 0, 0, 0);
    send_random(60, 1'b1);
    configure(0, 0, 0, 11520);
    @(negedge clk);
    send_sample(16'sd0, 17'sd0);
    send_sample(16'sd1, 17'sd1);
    send_sample(-16'sd1000, -17'sd1);
    in_valid <= 1'b0;
    send_random(80, 1'b1);
  endtask

  task automatic test_maximum_settings();
    configure(23040, 23040, 64000, 11520);
    send_random(120, 1'b1);
    configure(32767, 32767, 65535, 16383);
    send_random(60, 1'b0);
  endtask

  task automatic test_reversed_breakpoints();
    configure(16000, 3000, 500, 5000);
    send_random(120, 1'b1);
    configure(1000, 1300, 20000, 9000);
    send_random(120, 1'b1);
  endtask

  task automatic test_backpressure();
    configure(7680, 11520, 3200, 1280);
    hold_receiver = 1'b1;
    send_random(200, 1'b0);
  endtask

  initial begin
    stall_enable = 1'b1;
    forever begin
      repeat ($urandom_range(20, 200)) @(posedge clk);
      stall_enable = ~stall_enable;
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_receiver) begin
        out_stall <= 1'b1;
        repeat (150) @(negedge clk);
        hold_receiver = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= stall_enable && ($urandom_range(0, 3) == 0);
      end
    end
  end

  always @(posedge clk) begin
    offset_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_offsets.size() == 0) begin
        report_mismatch($sformatf("unexpected offset %0d", out_setpoint_offset));
      end else begin
        want = expected_offsets.pop_front();
        if (out_setpoint_offset !== want.offset)
          report_mismatch($sformatf("setpoint_offset got %0d want %0d",
                                    out_setpoint_offset, want.offset));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_arm_angle    = '0;
    in_arm_velocity = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_START;
    cfg_data        = '0;
    hold_receiver   = 1'b0;
    mismatch_count  = 0;
    idle_cycles     = 0;
    start_angle     = 7680;
    full_angle      = 11520;
    speed_threshold = 3200;
    offset_limit    = 1280;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_extremes();
    test_default_random();
    test_zero_thresholds();
    test_maximum_settings();
    test_reversed_breakpoints();
    test_backpressure();
    wait (expected_offsets.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
